[design/set_assoc_cache_tag_lookup_top_defines.svh]
// Assertion macros used by the cache tag lookup back end.
// Depends on nothing; included by files that assert.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define SACL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define SACL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[design/sacl_pkg.sv]
// Shared constants and types of the cache tag lookup.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sacl_pkg;
  localparam int Sets = 64;
  localparam int Ways = 4;
  localparam int AddrBits = 32;
  localparam int SetW = $clog2(Sets);
  localparam int WayW = $clog2(Ways);
  localparam int LineW = SetW + WayW;
  localparam int Lines = Sets * Ways;
  localparam logic [1:0] POL_LRU = 2'd0;
  localparam logic [1:0] POL_LFU = 2'd1;
  localparam logic [2:0] REG_SET_BITS = 3'd0;
  localparam logic [2:0] REG_BLOCK_BITS = 3'd1;
  localparam logic [2:0] REG_WAYS = 3'd2;
  localparam logic [2:0] REG_POLICY = 3'd3;
  localparam logic [2:0] REG_HIT_TIME = 3'd4;
  localparam logic [2:0] REG_MISS_PEN = 3'd5;
  // one classified beat passed from front to back
  typedef struct packed {
    logic [SetW-1:0] set;
    logic [31:0]     tag;
  } req_t;
endpackage
`default_nettype wire

[design/sacl_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sacl_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];
  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/sacl_front.sv]
// Front end: accepts addresses, splits set and tag, holds a one-entry queue.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sacl_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire [31:0]        in_address,
  input  wire [2:0]         set_bits,
  input  wire [4:0]         block_bits,
  input  wire               pop,
  input  wire               hold,
  output logic              busy,
  output logic              q_valid,
  output sacl_pkg::req_t    q_req
);
  logic           q_valid_r, q_valid_nxt;
  sacl_pkg::req_t q_req_r;
  sacl_pkg::req_t cls;
  logic [5:0]     sh;
  logic [31:0]    shifted;

  // classify the address
  always_comb begin
    sh = {1'b0, block_bits} + {3'b0, set_bits};
    shifted = in_address >> block_bits;
    cls.set = sacl_pkg::SetW'(shifted & ((32'd1 << set_bits) - 32'd1));
    cls.tag = (sh >= 6'd32) ? 32'd0 : (in_address >> sh);
  end

  // refuse beats while a beat is queued or the back end is still clearing
  assign busy = q_valid_r | hold;
  assign q_valid = q_valid_r;
  assign q_req = q_req_r;

  // hold one beat until the back end takes it
  always_comb begin
    q_valid_nxt = q_valid_r;
    if (pop) q_valid_nxt = 1'b0;
    if (start && !busy) q_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_valid_r <= 1'b0;
    else q_valid_r <= q_valid_nxt;
    if (start && !busy) q_req_r <= cls;
  end
endmodule
`default_nettype wire

[design/sacl_back.sv]
// Back end: reads the set, compares tags, picks the victim, updates state.
// Depends on sacl_pkg, sacl_ram and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_tag_lookup_top_defines.svh"
module sacl_back (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_valid,
  input  sacl_pkg::req_t  q_req,
  input  wire [2:0]       ways_in_use,
  input  wire [1:0]       policy,
  input  wire [7:0]       hit_time,
  input  wire [9:0]       miss_penalty,
  output logic            pop,
  output logic            clearing,
  output logic            out_valid,
  output logic            out_hit,
  output logic [1:0]      out_way_used,
  output logic            out_evicted,
  output logic [31:0]     out_reference_count,
  output logic [31:0]     out_miss_count,
  output logic [31:0]     out_time_total
);
  localparam int W = sacl_pkg::Ways;
  localparam int LW = sacl_pkg::LineW;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [sacl_pkg::SetW-1:0] clr_r;
  logic [sacl_pkg::SetW-1:0] ram_addr;
  logic [sacl_pkg::Lines-1:0] valid_r;
  logic [W-1:0][31:0] tag_q, stamp_q;
  logic [W-1:0][15:0] cnt_q;
  logic [31:0] acc_r, ref_r, miss_r, cyc_r;
  logic [W-1:0][31:0] stamp_rd;
  logic [W-1:0][15:0] cnt_rd;
  logic [W-1:0][31:0] tag_rd;
  logic [W-1:0] wv;
  logic [$clog2(W+1)-1:0] nw;
  logic hit, found_inv, evict;
  logic [sacl_pkg::WayW-1:0] way;
  logic [31:0] acc_n;
  logic [32:0] cyc_add;
  logic [33:0] cyc_sum;
  logic [LW-1:0] line;
  logic [W-1:0] we_stamp, we_cnt, we_tag;
  logic [15:0] cnt_w;
  logic [31:0] stamp_wd;
  logic [15:0] cnt_wd;
  logic hit_r, ev_r;
  logic [sacl_pkg::WayW-1:0] way_r;

  // sweep the sets after reset, otherwise address the queued set
  assign clearing = (st_r == ST_CLR);
  assign ram_addr = clearing ? clr_r : q_req.set;
  assign stamp_wd = clearing ? 32'd0 : acc_n;
  assign cnt_wd = clearing ? 16'd0 : cnt_w;

  // per-way memories, all addressed by set
  for (genvar g = 0; g < W; g++) begin : g_way
    sacl_ram #(.Width(32), .Depth(sacl_pkg::Sets)) u_tag (
      .clk, .we(we_tag[g]), .waddr(ram_addr), .wdata(q_req.tag),
      .raddr(ram_addr), .rdata(tag_rd[g]));
    sacl_ram #(.Width(32), .Depth(sacl_pkg::Sets)) u_stamp (
      .clk, .we(we_stamp[g]), .waddr(ram_addr), .wdata(stamp_wd),
      .raddr(ram_addr), .rdata(stamp_rd[g]));
    sacl_ram #(.Width(16), .Depth(sacl_pkg::Sets)) u_cnt (
      .clk, .we(we_cnt[g]), .waddr(ram_addr), .wdata(cnt_wd),
      .raddr(ram_addr), .rdata(cnt_rd[g]));
    // stamp and count entries start at zero after the clearing sweep
    assign stamp_q[g] = stamp_rd[g];
    assign cnt_q[g] = cnt_rd[g];
    assign tag_q[g] = tag_rd[g];
    assign wv[g] = valid_r[{q_req.set, sacl_pkg::WayW'(g)}];
  end

  // tag compare and victim choice
  always_comb begin
    nw = (ways_in_use == 3'd0) ? 3'd1 :
         ((ways_in_use > 3'(W)) ? 3'(W) : ways_in_use[$clog2(W+1)-1:0]);
    hit = 1'b0; found_inv = 1'b0; way = '0;
    for (int i = W - 1; i >= 0; i--)
      if (i < nw && wv[i] && tag_q[i] == q_req.tag) begin
        hit = 1'b1; way = sacl_pkg::WayW'(i);
      end
    if (!hit) begin
      for (int i = 0; i < W; i++)
        if (i < nw && !wv[i]) begin found_inv = 1'b1; way = sacl_pkg::WayW'(i); end
      if (!found_inv) begin
        way = '0;
        for (int i = 1; i < W; i++)
          if (i < nw) begin
            if (policy == sacl_pkg::POL_LRU && stamp_q[i] < stamp_q[way])
              way = sacl_pkg::WayW'(i);
            if (policy == sacl_pkg::POL_LFU && cnt_q[i] < cnt_q[way])
              way = sacl_pkg::WayW'(i);
          end
      end
    end
    evict = !hit && !found_inv;
    line = {q_req.set, way};
    acc_n = (acc_r == 32'hFFFF_FFFF) ? acc_r : acc_r + 32'd1;
    cnt_w = !hit ? 16'd1 : ((cnt_q[way] == 16'hFFFF) ? cnt_q[way] : cnt_q[way] + 16'd1);
    cyc_add = hit ? {25'd0, hit_time} : {22'd0, {2'b0, hit_time} + {1'b0, miss_penalty}};
    cyc_sum = {2'b0, cyc_r} + {1'b0, cyc_add};
    we_stamp = '0; we_cnt = '0; we_tag = '0;
    if (st_r == ST_CLR) begin
      we_stamp = '1; we_cnt = '1;
    end
    if (st_r == ST_EVAL) begin
      if (policy == sacl_pkg::POL_LRU) we_stamp[way] = 1'b1;
      if (policy == sacl_pkg::POL_LFU) we_cnt[way] = 1'b1;
      if (!hit) we_tag[way] = 1'b1;
    end
  end

  // sequencer: clear once, then read, evaluate, show result
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR:  if (clr_r == sacl_pkg::SetW'(sacl_pkg::Sets - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (q_valid) st_nxt = ST_READ;
      ST_READ: st_nxt = ST_EVAL;
      ST_EVAL: st_nxt = ST_OUT;
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign pop = (st_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR; clr_r <= '0; valid_r <= '0;
      acc_r <= '0; ref_r <= '0; miss_r <= '0; cyc_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLR) clr_r <= clr_r + 1'b1;
      if (st_r == ST_EVAL) begin
        acc_r <= acc_n;
        if (ref_r != 32'hFFFF_FFFF) ref_r <= ref_r + 32'd1;
        if (!hit && miss_r != 32'hFFFF_FFFF) miss_r <= miss_r + 32'd1;
        cyc_r <= (cyc_sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : cyc_sum[31:0];
        valid_r[line] <= 1'b1;
      end
    end
    if (st_r == ST_EVAL) begin
      hit_r <= hit; way_r <= way; ev_r <= evict;
    end
  end

  assign out_valid = pop;
  assign out_hit = hit_r;
  assign out_way_used = 2'(way_r);
  assign out_evicted = ev_r;
  assign out_reference_count = ref_r;
  assign out_miss_count = miss_r;
  assign out_time_total = cyc_r;

  `SACL_ASSERT_IMP(a_hit_no_evict, out_valid, !(out_hit && out_evicted), "hit with eviction")
  `SACL_ASSERT_NXT(a_eval_to_out, st_r == ST_EVAL, out_valid, "result not shown after eval")
  `SACL_ASSERT_IMP(a_pop_needs_q, pop, q_valid, "pop without queued beat")
endmodule
`default_nettype wire

[design/set_assoc_cache_tag_lookup_top.sv]
// An address is taken when start is high and busy is low; its result appears
// on the out_ ports for one cycle with out_valid, after the back end has gone
// through its READ and EVAL states, and cannot be held off. Each address passes
// through queue and RAM read, read settle, compare and update, and result,
// after which busy drops for the next address. After reset busy stays high
// while the stamp and count memories of all 64 sets are cleared.
// Configuration writes are always ready.
// Depends on sacl_pkg, sacl_front, sacl_back.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_tag_lookup_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire [31:0]  in_address,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [2:0]   cfg_index,
  input  wire [31:0]  cfg_data,
  output logic        out_valid,
  output logic        out_hit,
  output logic [1:0]  out_way_used,
  output logic        out_evicted,
  output logic [31:0] out_reference_count,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_time_total
);
  logic [2:0] set_bits_r, ways_r;
  logic [4:0] block_bits_r;
  logic [1:0] policy_r;
  logic [7:0] hit_time_r;
  logic [9:0] miss_pen_r;
  logic q_valid, pop, clearing;
  sacl_pkg::req_t q_req;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= 3'd6; block_bits_r <= 5'd4; ways_r <= 3'd4;
      policy_r <= 2'd0; hit_time_r <= 8'd1; miss_pen_r <= 10'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sacl_pkg::REG_SET_BITS:   set_bits_r <= cfg_data[2:0];
        sacl_pkg::REG_BLOCK_BITS: block_bits_r <= cfg_data[4:0];
        sacl_pkg::REG_WAYS:       ways_r <= cfg_data[2:0];
        sacl_pkg::REG_POLICY:     policy_r <= cfg_data[1:0];
        sacl_pkg::REG_HIT_TIME:   hit_time_r <= cfg_data[7:0];
        sacl_pkg::REG_MISS_PEN:   miss_pen_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  sacl_front u_front (
    .clk, .rst_n, .start, .in_address, .set_bits(set_bits_r),
    .block_bits(block_bits_r), .pop, .hold(clearing), .busy, .q_valid, .q_req);

  sacl_back u_back (
    .clk, .rst_n, .q_valid, .q_req, .ways_in_use(ways_r), .policy(policy_r),
    .hit_time(hit_time_r), .miss_penalty(miss_pen_r), .pop, .clearing, .out_valid,
    .out_hit, .out_way_used, .out_evicted, .out_reference_count,
    .out_miss_count, .out_time_total);
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking bench for the set-associative cache tag lookup top level.
// Depends on sacl_pkg and set_assoc_cache_tag_lookup_top; drives address beats
// and configuration writes, and checks every result against its own cache model.
`timescale 1ns / 1ps
module tb;
  import sacl_pkg::*;

  typedef struct {
    logic        hit;
    logic [1:0]  way;
    logic        evicted;
    logic [31:0] refs;
    logic [31:0] misses;
    logic [31:0] cycles;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [31:0] in_address = '0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  wire busy, cfg_ready, out_valid, out_hit, out_evicted;
  wire [1:0] out_way_used;
  wire [31:0] out_reference_count, out_miss_count, out_time_total;

  set_assoc_cache_tag_lookup_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_address(in_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_hit(out_hit),
    .out_way_used(out_way_used), .out_evicted(out_evicted),
    .out_reference_count(out_reference_count), .out_miss_count(out_miss_count),
    .out_time_total(out_time_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cache model state
  logic [2:0]  m_set_bits, m_ways;
  logic [4:0]  m_block_bits;
  logic [1:0]  m_policy;
  logic [7:0]  m_hit_time;
  logic [9:0]  m_miss_pen;
  logic        m_valid [Lines];
  logic [31:0] m_tag [Lines];
  logic [15:0] m_count [Lines];
  logic [31:0] m_stamp [Lines];
  logic [31:0] m_access, m_refs, m_misses, m_cycles;

  logic [31:0]  addr_q[$];
  lookup_res_t  lookup_q[$];
  int  errors = 0;
  int  results_seen = 0, hits_seen = 0, evicts_seen = 0;
  bit  idle_ok = 1'b1;
  bit  in_taken = 1'b0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [32:0] b);
    logic [33:0] s;
    s = a + b;
    return (s > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic model_reset();
    m_set_bits = 3'd6; m_block_bits = 5'd4; m_ways = 3'd4;
    m_policy = POL_LRU; m_hit_time = 8'd1; m_miss_pen = 10'd100;
    for (int i = 0; i < Lines; i++) begin
      m_valid[i] = 1'b0; m_tag[i] = '0; m_count[i] = '0; m_stamp[i] = '0;
    end
    m_access = '0; m_refs = '0; m_misses = '0; m_cycles = '0;
  endtask

  task automatic model_config(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_SET_BITS:   m_set_bits = val[2:0];
      REG_BLOCK_BITS: m_block_bits = val[4:0];
      REG_WAYS:       m_ways = val[2:0];
      REG_POLICY:     m_policy = val[1:0];
      REG_HIT_TIME:   m_hit_time = val[7:0];
      REG_MISS_PEN:   m_miss_pen = val[9:0];
      default: ;
    endcase
  endtask

  task automatic touch_line(int line, bit fill);
    if (m_policy == POL_LRU) begin
      m_stamp[line] = m_access;
    end else if (m_policy == POL_LFU) begin
      if (fill) m_count[line] = 16'd1;
      else if (m_count[line] != 16'hFFFF) m_count[line] = m_count[line] + 16'd1;
    end
  endtask

  // Compute the expected result of one lookup and update the model
  task automatic predict_lookup(logic [31:0] addr, output lookup_res_t r);
    int sh, base, nw, way;
    logic [31:0] tag;
    logic [63:0] sidx;
    bit hit, ev, found;
    sh = m_set_bits + m_block_bits;
    tag = (sh >= AddrBits) ? 32'd0 : addr >> sh;
    sidx = ({32'd0, addr} >> m_block_bits) & ((64'd1 << m_set_bits) - 64'd1);
    base = int'(sidx % Sets) * Ways;
    nw = (m_ways == 0) ? 1 : ((m_ways > Ways) ? Ways : m_ways);
    hit = 0; ev = 0; found = 0; way = 0;
    m_access = sat_add(m_access, 1);
    m_refs = sat_add(m_refs, 1);
    for (int w = 0; w < nw; w++)
      if (!hit && m_valid[base + w] && m_tag[base + w] == tag) begin
        hit = 1; way = w;
      end
    if (hit) begin
      m_cycles = sat_add(m_cycles, m_hit_time);
      touch_line(base + way, 0);
    end else begin
      m_misses = sat_add(m_misses, 1);
      m_cycles = sat_add(m_cycles, m_hit_time + m_miss_pen);
      for (int w = 0; w < nw; w++)
        if (!m_valid[base + w]) begin
          way = w; found = 1;
        end
      if (!found) begin
        ev = 1; way = 0;
        for (int w = 1; w < nw; w++) begin
          if (m_policy == POL_LRU && m_stamp[base + w] < m_stamp[base + way]) way = w;
          if (m_policy == POL_LFU && m_count[base + w] < m_count[base + way]) way = w;
        end
      end
      m_valid[base + way] = 1'b1;
      m_tag[base + way] = tag;
      touch_line(base + way, 1);
    end
    r.hit = hit; r.way = way[1:0]; r.evicted = ev;
    r.refs = m_refs; r.misses = m_misses; r.cycles = m_cycles;
  endtask

  // Drive address beats from the pending queue, idling at random unless idle_ok is set
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        // the beat was taken at the last rising edge
        void'(addr_q.pop_front());
      end
      if (in_taken || !start) begin
        if (addr_q.size() > 0 && (idle_ok ? 1 : ($urandom_range(0, 99) >= 32))) begin
          start <= 1'b1;
          in_address <= addr_q[0];
        end else begin
          start <= 1'b0;
          in_address <= $urandom;
        end
      end
    end
  end

  // Predict on accepted beats and check every result strobe
  always @(posedge clk) begin
    lookup_res_t r, e;
    in_taken = rst_n && start && !busy;
    if (in_taken) begin
      predict_lookup(in_address, r);
      lookup_q.push_back(r);
    end
    if (rst_n && out_valid) begin
      results_seen++;
      if (lookup_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = lookup_q.pop_front();
        if (out_hit !== e.hit || out_way_used !== e.way || out_evicted !== e.evicted ||
            out_reference_count !== e.refs || out_miss_count !== e.misses ||
            out_time_total !== e.cycles) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp h%0d w%0d e%0d r%0d m%0d t%0d got h%0d w%0d e%0d r%0d m%0d t%0d",
                     e.hit, e.way, e.evicted, e.refs, e.misses, e.cycles, out_hit,
                     out_way_used, out_evicted, out_reference_count, out_miss_count,
                     out_time_total);
        end
        if (e.hit) hits_seen++;
        if (e.evicted) evicts_seen++;
      end
    end
  end

  task automatic wait_drained();
    while (addr_q.size() > 0 || lookup_q.size() > 0 || start) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick addresses biased towards a few sets and tags so hits and evictions occur
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 9) < 8) a = a & 32'h0000_0F3F | (a[31:30] << 12);
    return a;
  endfunction

  initial begin
    logic [31:0] dir_addr [] = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0010, 32'h0000_0400,
                                 32'h0000_0800, 32'h0000_0C00, 32'h0000_1000,
                                 32'h0000_0000, 32'h8000_0000, 32'h5555_5555,
                                 32'hAAAA_AAAA, 32'h0000_1400};
    model_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: fills, hits and evictions under reset settings
    foreach (dir_addr[i]) addr_q.push_back(dir_addr[i]);
    wait_drained();
    // phases across all policies and extreme geometries
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin write_reg(REG_SET_BITS, 0); write_reg(REG_BLOCK_BITS, 16); end
        1: begin write_reg(REG_SET_BITS, 6); write_reg(REG_BLOCK_BITS, 0); end
        2: begin write_reg(REG_SET_BITS, 7); write_reg(REG_BLOCK_BITS, 31); end
        default: begin
          write_reg(REG_SET_BITS, $urandom_range(0, 7));
          write_reg(REG_BLOCK_BITS, $urandom_range(0, 4) == 0 ? $urandom : 4);
        end
      endcase
      write_reg(REG_WAYS, ph == 1 ? 0 : (ph == 2 ? 7 : $urandom_range(1, 4)));
      write_reg(REG_POLICY, ph % 4);
      write_reg(REG_HIT_TIME, ph == 0 ? 255 : (ph == 1 ? 0 : $urandom));
      write_reg(REG_MISS_PEN, ph == 0 ? 1023 : (ph == 1 ? 0 : $urandom));
      idle_ok = (ph == 4);
      for (int i = 0; i < 124; i++) addr_q.push_back(pick_addr());
      wait_drained();
    end
    $display("covered %0d lookups: %0d hits, %0d evictions over ten settings",
             results_seen, hits_seen, evicts_seen);
    if (errors == 0) $display("[set_assoc_cache_tag_lookup_top] OK");
    else $display("[set_assoc_cache_tag_lookup_top] ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("[set_assoc_cache_tag_lookup_top] ERROR");
    $finish;
  end
endmodule
